[rtl/iut_pkg.sv]
// Shared types, sizes and codes for the interval union table.
// Used by iut_cell and interval_union_table; depends on nothing else.
`default_nettype none
package iut_pkg;
  localparam int CAPACITY = 32;
  localparam int COORD_W  = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_OVERLAP = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ORDER = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_MERGE  = 2'd2,
    OP_SHIFTL = 2'd3
  } cell_op_t;

  // Values carried from one cell to the next during a scan.
  typedef struct packed {
    logic [COORD_W-1:0] psum;
    logic [COORD_W-1:0] mn;
    logic [COORD_W-1:0] mx;
    logic [CNT_W-1:0]   lo_cnt;
    logic [CNT_W-1:0]   k_cnt;
  } chain_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    cell_op_t           op;
    logic [CNT_W-1:0]   lo;
    logic [COORD_W-1:0] nb;
    logic [COORD_W-1:0] ne;
    logic [COORD_W-1:0] b;
    logic [COORD_W-1:0] e;
    logic               is_add;
    logic [CNT_W-1:0]   count;
  } cell_ctrl_t;
endpackage
`default_nettype wire

[rtl/iut_cell.sv]
// One table slot: stores one interval and adds its part to the scan chain.
// Depends on iut_pkg.
`default_nettype none
module iut_cell (
  input  wire                        clk,
  input  wire [iut_pkg::CNT_W-1:0]   idx,
  input  wire iut_pkg::cell_ctrl_t   ctrl,
  input  wire iut_pkg::chain_t       chain_in,
  output iut_pkg::chain_t            chain_out,
  input  wire [iut_pkg::COORD_W-1:0] left_start,
  input  wire [iut_pkg::COORD_W-1:0] left_stop,
  input  wire [iut_pkg::COORD_W-1:0] right_start,
  input  wire [iut_pkg::COORD_W-1:0] right_stop,
  output logic [iut_pkg::COORD_W-1:0] start,
  output logic [iut_pkg::COORD_W-1:0] stop
);
  logic                        valid, below, above, merged, ovl;
  logic [iut_pkg::COORD_W-1:0] clip_lo, clip_hi, contrib;

  always_comb begin
    valid   = idx < ctrl.count;
    below   = stop < ctrl.b;
    above   = start > ctrl.e;
    merged  = valid && !below && !above;
    ovl     = valid && (stop > ctrl.b) && (start < ctrl.e);
    clip_lo = (start > ctrl.b) ? start : ctrl.b;
    clip_hi = (stop < ctrl.e) ? stop : ctrl.e;
    if (ctrl.is_add) begin
      contrib = merged ? (stop - start) : '0;
    end else begin
      contrib = ovl ? (clip_hi - clip_lo) : '0;
    end
  end

  always_ff @(posedge clk) begin
    chain_out.psum   <= chain_in.psum + contrib;
    chain_out.mn     <= (merged && start < chain_in.mn) ? start : chain_in.mn;
    chain_out.mx     <= (merged && stop > chain_in.mx) ? stop : chain_in.mx;
    chain_out.lo_cnt <= chain_in.lo_cnt + iut_pkg::CNT_W'(valid && below);
    chain_out.k_cnt  <= chain_in.k_cnt + iut_pkg::CNT_W'(merged);
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      iut_pkg::OP_INSERT: begin
        if (idx == ctrl.lo) begin
          start <= ctrl.nb;
          stop  <= ctrl.ne;
        end else if (idx > ctrl.lo) begin
          start <= left_start;
          stop  <= left_stop;
        end
      end
      iut_pkg::OP_MERGE: begin
        if (idx == ctrl.lo) begin
          start <= ctrl.nb;
          stop  <= ctrl.ne;
        end
      end
      iut_pkg::OP_SHIFTL: begin
        if (idx > ctrl.lo) begin
          start <= right_start;
          stop  <= right_stop;
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

[rtl/interval_union_table.sv]
// Interval union table: sorted disjoint half-open intervals with add, overlap and clear.
// Clear, empty add, reversed bounds and unused commands go from idle straight to the
// response state; add and overlap pass through scan, apply and response, and an add that
// merges more than one stored interval also shifts. Requests are taken one at a time.
// Reset (rst, synchronous) empties the table and the covered sum; slot contents stay.
// Depends on iut_pkg and iut_cell.
`default_nettype none
module interval_union_table (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,  // begin_pos [31:0], end_pos [63:32]
  input  wire  [1:0]  s_tuser,  // command [1:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [71:0] m_tdata   // status [1:0], overlap_length [33:2],
                                // covered_total [65:34], interval_count [71:66]
);
  localparam int N  = iut_pkg::CAPACITY;
  localparam int CW = iut_pkg::COORD_W;
  localparam int NW = iut_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_APPLY = 5'b00100,
    S_SHIFT = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t          state;
  logic [1:0]      cmd;
  logic [CW-1:0]   bpos, epos;
  logic [NW-1:0]   count;
  logic [CW-1:0]   covered_sum;
  logic [NW-1:0]   scan_cnt;
  logic [NW-1:0]   shift_cnt;
  logic [NW-1:0]   lo_reg;
  logic [1:0]      res_status;
  logic [CW-1:0]   res_ovl;
  logic            accept;
  logic [CW-1:0]   in_b, in_e;

  iut_pkg::chain_t     chain [N+1];
  iut_pkg::cell_ctrl_t ctrl;
  iut_pkg::chain_t     fin;
  logic [CW-1:0]       cstart [N];
  logic [CW-1:0]       cstop  [N];
  logic                full_rej;

  assign in_b     = s_tdata[CW-1:0];
  assign in_e     = s_tdata[2*CW-1:CW];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign fin      = chain[N];
  assign full_rej = (fin.k_cnt == '0) && (count >= NW'(N));

  // The head of the chain starts from the request bounds so that an add with no
  // merge partner keeps its own begin and end.
  assign chain[0] = '{psum: '0, mn: bpos, mx: epos, lo_cnt: '0, k_cnt: '0};

  always_comb begin
    ctrl        = '0;
    ctrl.op     = iut_pkg::OP_HOLD;
    ctrl.lo     = lo_reg;
    ctrl.nb     = fin.mn;
    ctrl.ne     = fin.mx;
    ctrl.b      = bpos;
    ctrl.e      = epos;
    ctrl.is_add = (cmd == iut_pkg::CMD_ADD);
    ctrl.count  = count;
    if (state == S_APPLY && cmd == iut_pkg::CMD_ADD && !full_rej) begin
      ctrl.lo = fin.lo_cnt;
      ctrl.op = (fin.k_cnt == '0) ? iut_pkg::OP_INSERT : iut_pkg::OP_MERGE;
    end else if (state == S_SHIFT) begin
      ctrl.op = iut_pkg::OP_SHIFTL;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    iut_cell u_cell (
      .clk        (clk),
      .idx        (NW'(i)),
      .ctrl       (ctrl),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1]),
      .left_start ((i == 0) ? '0 : cstart[(i == 0) ? 0 : i-1]),
      .left_stop  ((i == 0) ? '0 : cstop[(i == 0) ? 0 : i-1]),
      .right_start((i == N-1) ? '0 : cstart[(i == N-1) ? i : i+1]),
      .right_stop ((i == N-1) ? '0 : cstop[(i == N-1) ? i : i+1]),
      .start      (cstart[i]),
      .stop       (cstop[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      covered_sum <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // A result taken in the response state is replaced there by the next one.
      if (m_tvalid && m_tready && state != S_RESP) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd        <= s_tuser;
            bpos       <= in_b;
            epos       <= in_e;
            res_status <= iut_pkg::ST_OK;
            res_ovl    <= '0;
            scan_cnt   <= '0;
            state      <= S_RESP;
            if (s_tuser == iut_pkg::CMD_ADD || s_tuser == iut_pkg::CMD_OVERLAP) begin
              if (in_b > in_e) begin
                res_status <= iut_pkg::ST_BAD_ORDER;
              end else if (s_tuser == iut_pkg::CMD_OVERLAP || in_b != in_e) begin
                state <= S_SCAN;
              end
            end else if (s_tuser == iut_pkg::CMD_CLEAR) begin
              count       <= '0;
              covered_sum <= '0;
            end
          end
        end
        S_SCAN: begin
          // Every cell adds its share as the partial results ripple down the row.
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == NW'(N - 1)) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          state  <= S_RESP;
          lo_reg <= fin.lo_cnt;
          if (cmd == iut_pkg::CMD_OVERLAP) begin
            res_ovl <= fin.psum;
          end else if (full_rej) begin
            res_status <= iut_pkg::ST_FULL;
          end else begin
            covered_sum <= covered_sum - fin.psum + (fin.mx - fin.mn);
            if (fin.k_cnt == '0) begin
              count <= count + 1'b1;
            end else begin
              count <= count - (fin.k_cnt - 1'b1);
              if (fin.k_cnt > NW'(1)) begin
                shift_cnt <= fin.k_cnt - 1'b1;
                state     <= S_SHIFT;
              end
            end
          end
        end
        S_SHIFT: begin
          // Close the gap left by merged slots one position per cycle.
          shift_cnt <= shift_cnt - 1'b1;
          if (shift_cnt == NW'(1)) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {count, covered_sum, res_ovl, res_status};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= NW'(N))
    else $error("interval count above capacity");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second request taken while one is in flight");
  a_shift_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> shift_cnt != '0)
    else $error("compaction step with no slots left to close");
  a_scan_to_apply: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && scan_cnt == NW'(N - 1) |=> state == S_APPLY)
    else $error("scan did not end after a full pass of the row");
endmodule
`default_nettype wire

[tb/interval_union_table_test.sv]
// Self-checking testbench for interval_union_table: add, overlap and clear requests
// are predicted by a behavioral interval table and compared with every result.
// Depends on iut_pkg and the interval_union_table RTL.
`default_nettype none
module interval_union_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Fields from the lowest bit up: status, overlap, total, count.
  typedef struct packed {
    logic [5:0]  count;
    logic [31:0] total;
    logic [31:0] overlap;
    logic [1:0]  status;
  } outcome_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] bpos;
    logic [31:0] epos;
  } request_t;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_OFF   = 400;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;

  interval_union_table u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Predictor state: a sorted list of disjoint half-open intervals.
  logic [31:0] span_lo [iut_pkg::CAPACITY];
  logic [31:0] span_hi [iut_pkg::CAPACITY];
  int          span_cnt;
  logic [31:0] span_sum;

  request_t    pending_reqs[$];
  outcome_t    expected_outcomes[$];
  bit          failed;
  bit          stimulus_done;
  int          hold_off_left;    // receiver long stall, counted in its own process
  int          idle_cycles;

  // Insert [b,e) and merge with every stored interval that overlaps or touches it.
  function automatic logic [1:0] table_add(logic [31:0] b, logic [31:0] e);
    int lo, hi, k;
    logic [31:0] nb, ne, removed;
    if (b > e) return iut_pkg::ST_BAD_ORDER;
    if (b == e) return iut_pkg::ST_OK;
    lo = 0;
    while (lo < span_cnt && span_hi[lo] < b) lo++;
    hi = lo;
    while (hi < span_cnt && span_lo[hi] <= e) hi++;
    k = hi - lo;
    if (k == 0 && span_cnt >= iut_pkg::CAPACITY) return iut_pkg::ST_FULL;
    nb = b;
    ne = e;
    removed = '0;
    if (k > 0) begin
      if (span_lo[lo] < nb) nb = span_lo[lo];
      if (span_hi[hi-1] > ne) ne = span_hi[hi-1];
      for (int i = lo; i < hi; i++) removed += span_hi[i] - span_lo[i];
    end
    if (k == 0) begin
      for (int i = span_cnt; i > lo; i--) begin
        span_lo[i] = span_lo[i-1];
        span_hi[i] = span_hi[i-1];
      end
      span_cnt++;
    end else if (k > 1) begin
      for (int i = hi; i < span_cnt; i++) begin
        span_lo[i-k+1] = span_lo[i];
        span_hi[i-k+1] = span_hi[i];
      end
      span_cnt -= k - 1;
    end
    span_lo[lo] = nb;
    span_hi[lo] = ne;
    span_sum = span_sum - removed + (ne - nb);
    return iut_pkg::ST_OK;
  endfunction

  function automatic logic [31:0] table_overlap(logic [31:0] b, logic [31:0] e);
    logic [31:0] acc, lo, hi;
    acc = '0;
    for (int i = 0; i < span_cnt; i++) begin
      if (span_hi[i] > b && span_lo[i] < e) begin
        lo = span_lo[i] > b ? span_lo[i] : b;
        hi = span_hi[i] < e ? span_hi[i] : e;
        acc += hi - lo;
      end
    end
    return acc;
  endfunction

  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    o = '0;
    case (r.cmd)
      iut_pkg::CMD_ADD: begin
        o.status = table_add(r.bpos, r.epos);
      end
      iut_pkg::CMD_OVERLAP: begin
        if (r.bpos > r.epos) o.status = iut_pkg::ST_BAD_ORDER;
        else o.overlap = table_overlap(r.bpos, r.epos);
      end
      iut_pkg::CMD_CLEAR: begin
        span_cnt = 0;
        span_sum = '0;
      end
      default: ;
    endcase
    o.total = span_sum;
    o.count = 6'(span_cnt);
    return o;
  endfunction

  task automatic queue_request(logic [1:0] c, logic [31:0] b, logic [31:0] e);
    request_t r;
    r.cmd = c;
    r.bpos = b;
    r.epos = e;
    pending_reqs = {pending_reqs, r};
  endtask

  // A marker with command 3, begin all ones and end DEAD_0000 means "drain first";
  // it is never sent. Command 3 itself is still sent as a real no-op elsewhere.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Coordinates mostly drawn from a small window so intervals meet and merge.
  function automatic logic [31:0] pick_coord(int window);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return $urandom();
    if (sel == 1) return 32'hFFFF_FFFF - $urandom_range(0, 64);
    return $urandom_range(0, window);
  endfunction

  // Stimulus.
  initial begin
    int window, n;
    logic [31:0] b, e;
    logic [1:0]  c;
    span_cnt = 0;
    span_sum = '0;
    failed = 1'b0;
    stimulus_done = 1'b0;

    // Directed part: extremes, every command, each special case.
    queue_request(iut_pkg::CMD_OVERLAP, 32'd0, 32'hFFFF_FFFF);  // query on an empty table
    queue_request(iut_pkg::CMD_ADD, 32'd10, 32'd20);
    queue_request(iut_pkg::CMD_ADD, 32'd20, 32'd30);            // touches at the end
    queue_request(iut_pkg::CMD_ADD, 32'd5, 32'd10);             // touches at the start
    queue_request(iut_pkg::CMD_ADD, 32'd40, 32'd40);            // empty add
    queue_request(iut_pkg::CMD_ADD, 32'd50, 32'd45);            // begin after end
    queue_request(iut_pkg::CMD_OVERLAP, 32'd50, 32'd45);        // begin after end
    queue_request(iut_pkg::CMD_ADD, 32'd40, 32'd50);
    queue_request(iut_pkg::CMD_ADD, 32'd0, 32'd100);            // swallows both entries
    queue_request(iut_pkg::CMD_OVERLAP, 32'd50, 32'd200);
    queue_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(iut_pkg::CMD_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    queue_request(iut_pkg::CMD_OVERLAP, 32'd0, 32'hFFFF_FFFF);
    queue_request(iut_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'd0);
    queue_request(iut_pkg::CMD_ADD, 32'd0, 32'hFFFF_FFFF);      // largest interval
    queue_request(iut_pkg::CMD_OVERLAP, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_request(iut_pkg::CMD_CLEAR, 32'd0, 32'd0);
    // Fill to capacity, then one more disjoint add is rejected.
    for (int i = 0; i <= iut_pkg::CAPACITY; i++)
      queue_request(iut_pkg::CMD_ADD, 32'(i*4), 32'(i*4+2));
    queue_request(iut_pkg::CMD_ADD, 32'd2, 32'd4);        // merges two at full capacity
    queue_request(iut_pkg::CMD_ADD, 32'd1000, 32'd1001);  // disjoint add after the merge freed a slot
    queue_request(iut_pkg::CMD_OVERLAP, 32'd0, 32'd200);

    // Random part: phases alternating between two windows, each ends with a drain.
    n = 0;
    while (n < 800) begin
      window = (n / 120) % 2 == 0 ? 300 : 3000;
      for (int j = 0; j < 120 && n < 800; j++) begin
        c = $urandom_range(0, 99) < 55 ? iut_pkg::CMD_ADD :
            $urandom_range(0, 9) < 8 ? iut_pkg::CMD_OVERLAP :
            $urandom_range(0, 9) < 8 ? iut_pkg::CMD_CLEAR : CMD_UNUSED;
        b = pick_coord(window);
        e = $urandom_range(0, 9) == 0 ? pick_coord(window)
                                      : b + $urandom_range(0, window / 20);
        if (e < b && $urandom_range(0, 3) != 0) e = 32'hFFFF_FFFF;
        queue_request(c, b, e);
        n++;
      end
      queue_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hDEAD_0000);  // drain marker
    end
    stimulus_done = 1'b1;
  end

  function automatic bit is_drain_marker(request_t r);
    return r.cmd == CMD_UNUSED && r.bpos == 32'hFFFF_FFFF && r.epos == 32'hDEAD_0000;
  endfunction

  // Acceptance sampled at the rising edge, used by the driver at the next falling edge.
  bit s_tready_seen;
  always @(posedge clk) begin
    s_tready_seen <= s_tvalid && s_tready;
  end

  // Driver: bursts of random length separated by random gaps.
  int burst_left;
  int gap_left;
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!s_tvalid || s_tready_seen) begin
      if (pending_reqs.size() > 0 && is_drain_marker(pending_reqs[0])) begin
        s_tvalid <= 1'b0;
        if (expected_outcomes.size() == 0) void'(pending_reqs.pop_front());
      end else if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        request_t r;
        r = pending_reqs.pop_front();
        expected_outcomes = {expected_outcomes, apply_request(r)};
        s_tvalid <= 1'b1;
        s_tdata  <= {r.epos, r.bpos};
        s_tuser  <= r.cmd;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off early in the random part.
  int stall_phase;
  bit long_hold_done;
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_phase <= 0;
      hold_off_left <= 0;
      long_hold_done <= 1'b0;
    end else if (hold_off_left > 0) begin
      m_tready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (!long_hold_done && pending_reqs.size() < 700 &&
                 pending_reqs.size() > 0) begin
      long_hold_done <= 1'b1;
      hold_off_left <= HOLD_OFF;
      m_tready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      // Alternating stretches: always ready, then a mostly ready pseudo-random pattern.
      if ((stall_phase / 200) % 2 == 0) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Monitor and checker.
  always @(posedge clk) begin
    outcome_t got, want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        got = outcome_t'(m_tdata);
        if (expected_outcomes.size() == 0) begin
          $error("result with no request outstanding: %h", m_tdata);
          failed = 1'b1;
        end else begin
          want = expected_outcomes.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            failed = 1'b1;
          end
          if (got.overlap !== want.overlap) begin
            $error("overlap_length expected %0d actual %0d", want.overlap, got.overlap);
            failed = 1'b1;
          end
          if (got.total !== want.total) begin
            $error("covered_total expected %0d actual %0d", want.total, got.total);
            failed = 1'b1;
          end
          if (got.count !== want.count) begin
            $error("interval_count expected %0d actual %0d", want.count, got.count);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // End of run and watchdog.
  initial begin
    wait (rst == 1'b0);
    while (!(stimulus_done && pending_reqs.size() == 0 && !s_tvalid &&
             expected_outcomes.size() == 0) && idle_cycles < IDLE_LIMIT)
      @(posedge clk);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
    end else begin
      repeat (3 * iut_pkg::CAPACITY) @(posedge clk);
      if (!failed && expected_outcomes.size() == 0) begin
        $display("Test completed successfully");
      end else begin
        $display("Test completed with failures");
      end
    end
    $finish;
  end
endmodule
`default_nettype wire
